// ===== design/tcw_pkg.sv =====
// Shared constants, request and character codes, and cell address helper for the text console.
`default_nettype none
package tcw_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 4;
  localparam int CELLS    = ROWS * COLUMNS;

  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int CELL_W  = 16;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int SWEEP_W = $clog2(CELLS + 1);
  localparam int CNT_W   = $clog2(TAB_STOP + 1);
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REQ_PUT    = 2'd0;
  localparam logic [1:0] REQ_CURSOR = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_READ   = 2'd3;

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  localparam logic [3:0] FG_RESET = 4'd15;
  localparam logic [3:0] BG_RESET = 4'd0;
  localparam logic [CELL_W-1:0] RESET_CELL = {BG_RESET, FG_RESET, CH_SPACE};

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    cell_addr = ADDR_W'(int'(r) * COLUMNS + int'(c));
  endfunction

endpackage
`default_nettype wire

// ===== design/tcw_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== design/text_console_writer.sv =====
// Text console engine: request channel, result channel, colour registers and the cell store.
//
// One request word in, one result word out. A request puts a character at the
// cursor, sets the cursor, clears the screen or reads one cell; the result
// carries the cursor after the request and, for a read, the cell value.
// Colours are set through the APB port: fg_color at 0x0, bg_color at 0x4.
// Steps per request, from acceptance until the result is loaded:
//   put printable, return, newline, backspace, set cursor, read: the execute state only.
//   tab: one space is written per column up to the next tab stop.
//   any wrap or newline past the last row adds a scroll: the row copy
//   moves CELLS-COLUMNS cells (one cell per cycle over the single RAM read
//   and write port), then COLUMNS cells are written to blank the last row.
//   clear screen: all CELLS cells are written blank.
// After reset all CELLS (2000) cells of the store are swept to blank; no
// request is taken during the sweep, colour writes are taken as ever.
// A result waits in the output register while the receiver stalls; a request
// that finishes meanwhile holds until the register is free.
`default_nettype none
module text_console_writer (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [1:0]                 req_type_i,
  input  wire logic [7:0]                 char_code_i,
  input  wire logic [tcw_pkg::ROW_W-1:0]  target_row_i,
  input  wire logic [tcw_pkg::COL_W-1:0]  target_col_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [tcw_pkg::ROW_W-1:0]       cursor_row_o,
  output logic [tcw_pkg::COL_W-1:0]       cursor_col_o,
  output logic [tcw_pkg::CELL_W-1:0]      cell_value_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tcw_pkg::PADDR_W-1:0] paddr,
  input  wire logic [tcw_pkg::PDATA_W-1:0] pwdata,
  output logic [tcw_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);
  import tcw_pkg::*;

  localparam logic [2:0] ST_INIT      = 3'd0;
  localparam logic [2:0] ST_IDLE      = 3'd1;
  localparam logic [2:0] ST_EXEC      = 3'd2;
  localparam logic [2:0] ST_PUT       = 3'd3;
  localparam logic [2:0] ST_SCR_COPY  = 3'd4;
  localparam logic [2:0] ST_SCR_BLANK = 3'd5;
  localparam logic [2:0] ST_CLEAR     = 3'd6;
  localparam logic [2:0] ST_DONE      = 3'd7;

  localparam logic CFG_FG = 1'b0;
  localparam logic CFG_BG = 1'b1;

  logic [2:0]         state_q, state_d;
  logic [SWEEP_W-1:0] sweep_q, sweep_d;
  logic               pend_q, pend_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [3:0]         fg_q, bg_q;

  logic [1:0]         req_q;
  logic [7:0]         char_q;
  logic [ROW_W-1:0]   trow_q;
  logic [COL_W-1:0]   tcol_q;
  logic               inrange_q;

  logic               out_valid_q;
  logic [ROW_W-1:0]   out_row_q;
  logic [COL_W-1:0]   out_col_q;
  logic [CELL_W-1:0]  out_cell_q;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [CELL_W-1:0]  ram_wdata, ram_rdata;

  logic               accept, out_free, finish, load_out, do_put;
  logic [CNT_W-1:0]   put_cnt, tab_n;
  logic [ADDR_W-1:0]  cur_addr;
  logic [SWEEP_W-1:0] copy_dst;
  logic [7:0]         ch_put;
  logic [CELL_W-1:0]  blank, cell_rd;
  logic               cfg_wr;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign blank    = {bg_q, fg_q, CH_SPACE};
  assign cur_addr = cell_addr(row_q, col_q);
  assign tab_n    = CNT_W'(TAB_STOP - int'(col_q) % TAB_STOP);
  assign ch_put   = (char_q == CH_TAB) ? CH_SPACE : char_q;
  assign cell_rd  = (req_q == REQ_READ && inrange_q) ? ram_rdata : '0;
  assign copy_dst = sweep_q - SWEEP_W'(COLUMNS + 1);

  always_comb begin
    state_d   = state_q;
    sweep_d   = sweep_q;
    pend_d    = pend_q;
    row_d     = row_q;
    col_d     = col_q;
    cnt_d     = cnt_q;
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = blank;
    ram_re    = 1'b0;
    ram_raddr = cell_addr(target_row_i, target_col_i);
    finish    = 1'b0;
    load_out  = 1'b0;
    do_put    = 1'b0;
    put_cnt   = cnt_q;

    unique case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q[ADDR_W-1:0];
        ram_wdata = RESET_CELL;
        if (sweep_q == SWEEP_W'(CELLS - 1)) begin
          sweep_d = '0;
          state_d = ST_IDLE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          ram_re  = (req_type_i == REQ_READ);
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (req_q)
          REQ_PUT: begin
            case (char_q)
              CH_NEWLINE: begin
                col_d = '0;
                if (row_q == ROW_W'(ROWS - 1)) begin
                  cnt_d   = '0;
                  sweep_d = SWEEP_W'(COLUMNS);
                  pend_d  = 1'b0;
                  state_d = ST_SCR_COPY;
                end else begin
                  row_d  = row_q + 1'b1;
                  finish = 1'b1;
                end
              end
              CH_RETURN: begin
                col_d  = '0;
                finish = 1'b1;
              end
              CH_BACKSPACE: begin
                if (col_q != '0) begin
                  col_d     = col_q - 1'b1;
                  ram_we    = 1'b1;
                  ram_waddr = cur_addr - 1'b1;
                end
                finish = 1'b1;
              end
              CH_TAB: begin
                do_put  = 1'b1;
                put_cnt = tab_n;
              end
              default: begin
                do_put  = 1'b1;
                put_cnt = CNT_W'(1);
              end
            endcase
          end
          REQ_CURSOR: begin
            row_d  = (int'(trow_q) < ROWS) ? trow_q : ROW_W'(ROWS - 1);
            col_d  = (int'(tcol_q) < COLUMNS) ? tcol_q : COL_W'(COLUMNS - 1);
            finish = 1'b1;
          end
          REQ_CLEAR: begin
            sweep_d = '0;
            state_d = ST_CLEAR;
          end
          REQ_READ: begin
            finish = 1'b1;
          end
        endcase
      end
      ST_PUT: begin
        do_put = 1'b1;
      end
      ST_SCR_COPY: begin
        // read one row ahead, write back what came out last cycle
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = copy_dst[ADDR_W-1:0];
          ram_wdata = ram_rdata;
        end
        if (sweep_q != SWEEP_W'(CELLS)) begin
          ram_re    = 1'b1;
          ram_raddr = sweep_q[ADDR_W-1:0];
          sweep_d   = sweep_q + 1'b1;
          pend_d    = 1'b1;
        end else begin
          pend_d  = 1'b0;
          sweep_d = SWEEP_W'(CELLS - COLUMNS);
          state_d = ST_SCR_BLANK;
        end
      end
      ST_SCR_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q[ADDR_W-1:0];
        if (sweep_q == SWEEP_W'(CELLS - 1)) begin
          sweep_d = '0;
          if (cnt_q != '0) begin
            state_d = ST_PUT;
          end else begin
            finish = 1'b1;
          end
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q[ADDR_W-1:0];
        if (sweep_q == SWEEP_W'(CELLS - 1)) begin
          sweep_d = '0;
          row_d   = '0;
          col_d   = '0;
          finish  = 1'b1;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      ST_DONE: begin
        finish = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // one printable cell: write, advance, wrap and maybe scroll
    if (do_put) begin
      ram_we    = 1'b1;
      ram_waddr = cur_addr;
      ram_wdata = {bg_q, fg_q, ch_put};
      cnt_d     = put_cnt - 1'b1;
      if (col_q == COL_W'(COLUMNS - 1)) begin
        col_d = '0;
        if (row_q == ROW_W'(ROWS - 1)) begin
          sweep_d = SWEEP_W'(COLUMNS);
          pend_d  = 1'b0;
          state_d = ST_SCR_COPY;
        end else begin
          row_d = row_q + 1'b1;
          if (put_cnt == CNT_W'(1)) begin
            finish = 1'b1;
          end else begin
            state_d = ST_PUT;
          end
        end
      end else begin
        col_d = col_q + 1'b1;
        if (put_cnt == CNT_W'(1)) begin
          finish = 1'b1;
        end else begin
          state_d = ST_PUT;
        end
      end
    end

    if (finish) begin
      if (out_free) begin
        load_out = 1'b1;
        state_d  = ST_IDLE;
      end else begin
        state_d = ST_DONE;
      end
    end
  end

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_BG) ? PDATA_W'(bg_q) : PDATA_W'(fg_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      sweep_q     <= '0;
      pend_q      <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      cnt_q       <= '0;
      fg_q        <= FG_RESET;
      bg_q        <= BG_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      pend_q  <= pend_d;
      row_q   <= row_d;
      col_q   <= col_d;
      cnt_q   <= cnt_d;
      if (cfg_wr) begin
        if (paddr[2] == CFG_FG) begin
          fg_q <= pwdata[3:0];
        end else begin
          bg_q <= pwdata[3:0];
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q     <= req_type_i;
      char_q    <= char_code_i;
      trow_q    <= target_row_i;
      tcol_q    <= target_col_i;
      inrange_q <= (int'(target_row_i) < ROWS) && (int'(target_col_i) < COLUMNS);
    end
    if (load_out) begin
      out_row_q  <= row_d;
      out_col_q  <= col_d;
      out_cell_q <= cell_rd;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;
  assign cell_value_o = out_cell_q;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for the text console writer: random and directed requests checked against a predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam logic [PADDR_W-1:0] FG_ADDR = 3'd0;
  localparam logic [PADDR_W-1:0] BG_ADDR = 3'd4;

  typedef struct {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CELL_W-1:0] value;
  } console_result_t;

  class console_scoreboard;
    logic [CELL_W-1:0] screen [CELLS];
    int unsigned       cur_row;
    int unsigned       cur_col;
    logic [3:0]        fg;
    logic [3:0]        bg;
    console_result_t   want_q[$];
    int                mismatches;
    int                results_seen;

    function new();
      foreach (screen[i]) screen[i] = RESET_CELL;
      cur_row = 0;
      cur_col = 0;
      fg = FG_RESET;
      bg = BG_RESET;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void set_register(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
      case (addr)
        FG_ADDR: fg = data[3:0];
        BG_ADDR: bg = data[3:0];
        default: ;
      endcase
    endfunction

    function logic [CELL_W-1:0] space_cell();
      return {bg, fg, CH_SPACE};
    endfunction

    // Move every row up one, blank the bottom row in the current colours.
    function void roll_up();
      for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = space_cell();
      cur_row = ROWS - 1;
    endfunction

    function void line_feed();
      cur_col = 0;
      cur_row++;
      if (cur_row >= ROWS) roll_up();
    endfunction

    function void store_glyph(logic [7:0] ch);
      screen[cur_row * COLUMNS + cur_col] = {bg, fg, ch};
      cur_col++;
      if (cur_col >= COLUMNS) line_feed();
    endfunction

    function void note_request(logic [1:0] rq, logic [7:0] ch,
                               logic [ROW_W-1:0] tr, logic [COL_W-1:0] tc);
      console_result_t want;
      logic [CELL_W-1:0] cell_val;
      int                n;
      cell_val = '0;
      case (rq)
        REQ_PUT: begin
          if (ch == CH_NEWLINE) begin
            line_feed();
          end else if (ch == CH_RETURN) begin
            cur_col = 0;
          end else if (ch == CH_BACKSPACE) begin
            if (cur_col > 0) begin
              cur_col--;
              screen[cur_row * COLUMNS + cur_col] = space_cell();
            end
          end else if (ch == CH_TAB) begin
            // space count is fixed by the cursor column when the tab comes
            n = TAB_STOP - (cur_col % TAB_STOP);
            repeat (n) store_glyph(CH_SPACE);
          end else begin
            store_glyph(ch);
          end
        end
        REQ_CURSOR: begin
          cur_row = (int'(tr) < ROWS) ? int'(tr) : ROWS - 1;
          cur_col = (int'(tc) < COLUMNS) ? int'(tc) : COLUMNS - 1;
        end
        REQ_CLEAR: begin
          foreach (screen[i]) screen[i] = space_cell();
          cur_row = 0;
          cur_col = 0;
        end
        REQ_READ: begin
          if (int'(tr) < ROWS && int'(tc) < COLUMNS)
            cell_val = screen[int'(tr) * COLUMNS + int'(tc)];
        end
      endcase
      want.row = ROW_W'(cur_row);
      want.col = COL_W'(cur_col);
      want.value = cell_val;
      want_q.push_back(want);
    endfunction

    function void check_result(logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                               logic [CELL_W-1:0] v);
      console_result_t want;
      results_seen++;
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d with no request waiting: row %0d col %0d cell %h",
                   results_seen, r, c, v);
        return;
      end
      want = want_q.pop_front();
      if (want.row !== r || want.col !== c || want.value !== v) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result %0d mismatch: expected row %0d col %0d cell %h, ",
                    "got row %0d col %0d cell %h"},
                   results_seen, want.row, want.col, want.value, r, c, v);
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          req_type_i;
  logic [7:0]          char_code_i;
  logic [ROW_W-1:0]    target_row_i;
  logic [COL_W-1:0]    target_col_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [ROW_W-1:0]    cursor_row_o;
  logic [COL_W-1:0]    cursor_col_o;
  logic [CELL_W-1:0]   cell_value_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  console_scoreboard sb;
  int                tx_calm = 0;
  int                rx_calm = 0;
  bit                hold_off_req = 1'b0;

  text_console_writer u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .char_code_i  (char_code_i),
    .target_row_i (target_row_i),
    .target_col_i (target_col_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .cell_value_o (cell_value_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk_i = ~clk_i;

  // Gap before the next word: mostly random, with runs of back-to-back words.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  // Check results before noting requests: no result can belong to a word taken at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(cursor_row_o, cursor_col_o, cell_value_o);
      if (in_valid_i && in_ready_o)
        sb.note_request(req_type_i, char_code_i, target_row_i, target_col_i);
    end
  end

  task automatic send_item(logic [1:0] rq, logic [7:0] ch,
                           logic [ROW_W-1:0] tr, logic [COL_W-1:0] tc);
    int gap;
    in_valid_i   <= 1'b1;
    req_type_i   <= rq;
    char_code_i  <= ch;
    target_row_i <= tr;
    target_col_i <= tc;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [3:0] val);
    logic [PDATA_W-1:0] data;
    data = $urandom();
    data[3:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_register(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls per word, plus one long hold-off on request.
  initial begin
    int stall;
    out_ready_i <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = draw_gap(rx_calm);
      if (hold_off_req) begin
        stall = 400;
        hold_off_req = 1'b0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin
    int               pick;
    logic [1:0]       rq;
    logic [7:0]       ch;
    logic [ROW_W-1:0] tr;
    logic [COL_W-1:0] tc;
    logic [3:0]       fg_pick;
    logic [3:0]       bg_pick;

    sb = new();
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    req_type_i   <= '0;
    char_code_i  <= '0;
    target_row_i <= '0;
    target_col_i <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, reset colours.
    send_item(REQ_READ, 8'd0, 5'd0, 7'd0);
    send_item(REQ_READ, 8'd0, 5'd24, 7'd79);
    send_item(REQ_READ, 8'd0, 5'd31, 7'd127);
    send_item(REQ_PUT, 8'd65, 5'd0, 7'd0);
    send_item(REQ_PUT, 8'd0, 5'd31, 7'd127);
    send_item(REQ_PUT, 8'd255, 5'd0, 7'd0);
    send_item(REQ_PUT, CH_BACKSPACE, 5'd0, 7'd0);
    send_item(REQ_READ, 8'd0, 5'd0, 7'd2);
    send_item(REQ_PUT, CH_TAB, 5'd0, 7'd0);
    send_item(REQ_PUT, CH_TAB, 5'd0, 7'd0);
    send_item(REQ_CURSOR, 8'd0, 5'd3, 7'd0);
    send_item(REQ_PUT, CH_BACKSPACE, 5'd0, 7'd0);
    send_item(REQ_CURSOR, 8'd0, 5'd5, 7'd10);
    send_item(REQ_PUT, CH_RETURN, 5'd0, 7'd0);
    send_item(REQ_PUT, CH_NEWLINE, 5'd0, 7'd0);
    send_item(REQ_CURSOR, 8'd0, 5'd0, 7'd79);
    send_item(REQ_PUT, 8'd90, 5'd0, 7'd0);
    send_item(REQ_READ, 8'd0, 5'd0, 7'd79);
    send_item(REQ_CURSOR, 8'd0, 5'd31, 7'd127);
    send_item(REQ_PUT, 8'd113, 5'd0, 7'd0);
    send_item(REQ_READ, 8'd0, 5'd23, 7'd79);
    send_item(REQ_CURSOR, 8'd0, 5'd24, 7'd78);
    send_item(REQ_PUT, CH_TAB, 5'd0, 7'd0);
    send_item(REQ_PUT, CH_NEWLINE, 5'd0, 7'd0);
    send_item(REQ_CLEAR, 8'd0, 5'd0, 7'd0);
    send_item(REQ_READ, 8'd0, 5'd0, 7'd0);
    send_item(REQ_READ, 8'd0, 5'd25, 7'd0);
    send_item(REQ_READ, 8'd0, 5'd0, 7'd80);
    in_valid_i <= 1'b0;
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin fg_pick = 4'd0;  bg_pick = 4'd0;  end
        1: begin fg_pick = 4'd15; bg_pick = 4'd15; end
        2: begin fg_pick = 4'd0;  bg_pick = 4'd15; end
        3: begin fg_pick = 4'd15; bg_pick = 4'd0;  end
        default: begin
          fg_pick = 4'($urandom_range(0, 15));
          bg_pick = 4'($urandom_range(0, 15));
        end
      endcase
      apb_write(FG_ADDR, fg_pick);
      apb_write(BG_ADDR, bg_pick);
      if (p == 1) hold_off_req = 1'b1;
      for (int k = 0; k < 125; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) rq = REQ_PUT;
        else if (pick < 77) rq = REQ_CURSOR;
        else if (pick < 80) rq = REQ_CLEAR;
        else rq = REQ_READ;
        pick = $urandom_range(0, 99);
        if (pick < 6) ch = CH_NEWLINE;
        else if (pick < 10) ch = CH_RETURN;
        else if (pick < 18) ch = CH_BACKSPACE;
        else if (pick < 26) ch = CH_TAB;
        else ch = 8'($urandom_range(0, 255));
        tr = ($urandom_range(0, 6) == 0) ? ROW_W'($urandom_range(ROWS, 31))
                                         : ROW_W'($urandom_range(0, ROWS - 1));
        tc = ($urandom_range(0, 6) == 0) ? COL_W'($urandom_range(COLUMNS, 127))
                                         : COL_W'($urandom_range(0, COLUMNS - 1));
        // aim half the reads at the cursor row, where text has just landed
        if (rq == REQ_READ && $urandom_range(0, 1) == 1) tr = ROW_W'(sb.cur_row);
        send_item(rq, ch, tr, tc);
      end
      in_valid_i <= 1'b0;
      wait_idle();
    end

    repeat (40) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(40_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule
